// ===== src/modem_response_line_classifier_unit_defines.svh =====
// assertion macros used by the rtl file mrlc_back.sv
`ifndef MODEM_RESPONSE_LINE_CLASSIFIER_UNIT_DEFINES_SVH
`define MODEM_RESPONSE_LINE_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define MRLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrlc: same-cycle check failed");

// next-cycle implication
`define MRLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrlc: next-cycle check failed");

`endif

// ===== src/mrlc_pkg.sv =====
package mrlc_pkg;

  localparam int LINE_BYTES_DEFAULT = 64;
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  // markers, first character in the top byte
  localparam int LEN_BYPASS = 18;
  localparam int LEN_DOWN = 20;
  localparam int LEN_ADDR = 15;
  localparam logic [8*LEN_BYPASS-1:0] MARK_BYPASS = "AT-AB -BypassMode-";
  localparam logic [8*LEN_DOWN-1:0] MARK_DOWN = "AT-AB ConnectionDown";
  localparam logic [8*LEN_ADDR-1:0] MARK_ADDR = "AT-AB BDAddress";
  localparam int WIN_BYTES = LEN_DOWN;

  localparam int ADDR_OFFSET = 16;
  localparam int ADDR_LEN = 12;
  // bytes after the end of an address match: skipped ones, then captured ones
  localparam int CAP_SKIP = ADDR_OFFSET - LEN_ADDR;
  localparam int CAP_STEPS = CAP_SKIP + ADDR_LEN;
  localparam int CAP_W = $clog2(CAP_STEPS);

  localparam logic [1:0] LINK_UNKNOWN = 2'd0;
  localparam logic [1:0] LINK_CONNECTED = 2'd1;
  localparam logic [1:0] LINK_DISCONNECTED = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_CONNECTED = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;
  localparam logic [1:0] EV_ADDRESS = 2'd3;

  typedef struct packed {
    logic       newline;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic [1:0]  line_event;
    logic [47:0] address_high;
    logic [47:0] address_low;
  } res_t;

endpackage

// ===== src/mrlc_fifo.sv =====
module mrlc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mrlc_front.sv =====
module mrlc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    rx_byte,
  output logic          full,
  input  logic          cmd_pop,
  output mrlc_pkg::cmd_t cmd,
  output logic          cmd_empty
);

  import mrlc_pkg::*;

  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  // tag line ends so the back part knows when to scan
  always_comb begin
    cmd_in.data    = rx_byte;
    cmd_in.newline = (rx_byte == NEWLINE_CHAR);
  end

  mrlc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(cmd_in),
    .full   (full),
    .pop    (cmd_pop),
    .rd_data(cmd_bits),
    .empty  (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

// ===== src/mrlc_back.sv =====
`include "modem_response_line_classifier_unit_defines.svh"

module mrlc_back #(
  parameter int LINE_BYTES = mrlc_pkg::LINE_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  mrlc_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output mrlc_pkg::res_t res
);

  import mrlc_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_DONE} state_t;

  state_t state;

  logic [7:0]            mem [LINE_BYTES];
  logic [7:0]            rdata;
  logic [AW-1:0]         wp;
  logic                  wrapped;
  logic [1:0]            link_status;
  logic [1:0]            line_ev;
  logic [8*ADDR_LEN-1:0] addr_chars;

  // scan pipeline
  logic [AW-1:0]          ra;
  logic                   issuing;
  logic                   rvalid;
  logic                   rlast;
  logic                   rok;
  logic                   in_text;
  logic [8*WIN_BYTES-1:0] win;
  logic [8*WIN_BYTES-1:0] w_now;
  logic                   found_bypass;
  logic                   found_down;
  logic                   found_addr;
  logic                   cap_run;
  logic [CAP_W-1:0]       cap_cnt;
  logic [CAP_W-1:0]       cap_pos;
  logic [8*ADDR_LEN-1:0]  addr_buf;

  logic [7:0] b;
  logic       hit_bypass;
  logic       hit_down;
  logic       hit_addr;
  logic       take;

  assign take    = (state == S_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop = take;

  // entries not written since the last clear read as zero
  assign b     = rok ? rdata : 8'h00;
  assign w_now = {win[8*(WIN_BYTES-1)-1:0], b};

  // newest byte sits in the low byte of the window, so markers compare directly
  assign hit_bypass = in_text && (w_now[8*LEN_BYPASS-1:0] == MARK_BYPASS);
  assign hit_down   = in_text && (w_now[8*LEN_DOWN-1:0] == MARK_DOWN);
  assign hit_addr   = in_text && (w_now[8*LEN_ADDR-1:0] == MARK_ADDR);

  assign cap_pos = CAP_W'(CAP_STEPS - 1) - cap_cnt;

  assign res_push = (take && !cmd.newline) || ((state == S_DONE) && !res_full);

  always_comb begin
    res.link_state   = link_status;
    res.line_event   = (state == S_DONE) ? line_ev : EV_NONE;
    res.address_high = addr_chars[8*ADDR_LEN-1:48];
    res.address_low  = addr_chars[47:0];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mem[wp] <= cmd.data;
    end
    if ((state == S_SCAN) && issuing) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wp          <= '0;
      wrapped     <= 1'b0;
      link_status <= LINK_UNKNOWN;
      line_ev     <= EV_NONE;
      addr_chars  <= '0;
      issuing     <= 1'b0;
      rvalid      <= 1'b0;
      cap_run     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (wp == AW'(LINE_BYTES - 1)) begin
              wp      <= '0;
              wrapped <= 1'b1;
            end else begin
              wp <= wp + 1'b1;
            end
            if (cmd.newline) begin
              state        <= S_SCAN;
              ra           <= '0;
              issuing      <= 1'b1;
              rvalid       <= 1'b0;
              in_text      <= 1'b1;
              win          <= '0;
              found_bypass <= 1'b0;
              found_down   <= 1'b0;
              found_addr   <= 1'b0;
              cap_run      <= 1'b0;
              cap_cnt      <= '0;
              addr_buf     <= '0;
            end
          end
        end
        S_SCAN: begin
          rvalid <= issuing;
          if (issuing) begin
            rlast <= (ra == AW'(LINE_BYTES - 1));
            rok   <= wrapped || (ra < wp);
            ra    <= ra + 1'b1;
            if (ra == AW'(LINE_BYTES - 1)) begin
              issuing <= 1'b0;
            end
          end
          if (rvalid) begin
            win <= w_now;
            if (b == 8'h00) begin
              in_text <= 1'b0;
            end
            if (hit_bypass) begin
              found_bypass <= 1'b1;
            end
            if (hit_down) begin
              found_down <= 1'b1;
            end
            // capture runs on raw stored bytes, past the text end too
            if (cap_run) begin
              if (cap_cnt >= CAP_W'(CAP_SKIP)) begin
                addr_buf[{cap_pos, 3'b000} +: 8] <= b;
              end
              if (cap_cnt == CAP_W'(CAP_STEPS - 1)) begin
                cap_run <= 1'b0;
              end else begin
                cap_cnt <= cap_cnt + 1'b1;
              end
            end
            if (hit_addr && !found_addr) begin
              found_addr <= 1'b1;
              cap_run    <= 1'b1;
              cap_cnt    <= '0;
            end
            if (rlast) begin
              state <= S_COMMIT;
            end
          end
        end
        S_COMMIT: begin
          priority if (found_bypass) begin
            link_status <= LINK_CONNECTED;
            line_ev     <= EV_CONNECTED;
          end else if (found_down) begin
            link_status <= LINK_DISCONNECTED;
            line_ev     <= EV_DOWN;
          end else if (found_addr) begin
            link_status <= LINK_DISCONNECTED;
            line_ev     <= EV_ADDRESS;
            addr_chars  <= addr_buf;
          end else begin
            line_ev <= EV_NONE;
          end
          wp      <= '0;
          wrapped <= 1'b0;
          cap_run <= 1'b0;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MRLC_ASSERT_NOW(a_res_room, clk, rst, res_push, !res_full)
  `MRLC_ASSERT_NEXT(a_newline_scans, clk, rst, cmd_pop && cmd.newline, state == S_SCAN)
  `MRLC_ASSERT_NEXT(a_last_commits, clk, rst, (state == S_SCAN) && rvalid && rlast, (state == S_COMMIT) && !issuing)
  `MRLC_ASSERT_NEXT(a_store_cleared, clk, rst, state == S_COMMIT, (wp == '0) && !wrapped)
  `MRLC_ASSERT_NOW(a_event_after_scan, clk, rst, res_push && (res.line_event != EV_NONE), state == S_DONE)

endmodule

// ===== src/modem_response_line_classifier_unit.sv =====
// modem response line classifier
// input queue side: drive rx_byte and raise push; a byte is taken on a rising
// edge with push high and full low. the front holds a two-entry command queue.
// result queue side: a result is on link_state, line_event, address_high and
// address_low while empty is low; it is taken on an edge with pop high.
// every accepted byte yields exactly one result, in order.
// a byte that is not a newline is stored in the line store and its result
// is queued as the back takes it; bytes sustain one per cycle while no scan runs and the result queue has room.
// a newline starts a scan of the whole store through its single read port,
// then a commit state and a done state that queues the result; from the back
// taking the byte to the result being queued, later bytes wait in the command queue.
// rst (synchronous, active high) empties both queues, clears the line store,
// and sets the link state to unknown and the address to zero.
// when the receiver stops popping, the two-entry result queue fills, the back
// part halts, then the command queue fills and full rises.
module modem_response_line_classifier_unit #(
  parameter int LINE_BYTES = mrlc_pkg::LINE_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  link_state,
  output logic [1:0]  line_event,
  output logic [47:0] address_high,
  output logic [47:0] address_low
);

  import mrlc_pkg::*;

  cmd_t                    cmd;
  logic                    cmd_empty;
  logic                    cmd_pop;
  res_t                    res;
  logic                    res_push;
  logic                    res_full;
  logic [$bits(res_t)-1:0] res_bits;
  res_t                    res_q;

  mrlc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_byte  (rx_byte),
    .full     (full),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  mrlc_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  mrlc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .wr_data(res),
    .full   (res_full),
    .pop    (pop),
    .rd_data(res_bits),
    .empty  (empty)
  );

  assign res_q        = res_t'(res_bits);
  assign link_state   = res_q.link_state;
  assign line_event   = res_q.line_event;
  assign address_high = res_q.address_high;
  assign address_low  = res_q.address_low;

endmodule

// ===== verif/modem_response_line_classifier_unit_tb.sv =====
`timescale 1ns / 100ps

module modem_response_line_classifier_unit_tb;
  import mrlc_pkg::*;

  localparam int LINE_BYTES = LINE_BYTES_DEFAULT;
  localparam int MARK_W = 8 * WIN_BYTES;

  localparam logic [MARK_W-1:0] M_BYPASS = MARK_W'(MARK_BYPASS);
  localparam logic [MARK_W-1:0] M_DOWN = MARK_W'(MARK_DOWN);
  localparam logic [MARK_W-1:0] M_ADDR = MARK_W'(MARK_ADDR);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  link_state;
  logic [1:0]  line_event;
  logic [47:0] address_high;
  logic [47:0] address_low;

  modem_response_line_classifier_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .link_state(link_state),
    .line_event(line_event),
    .address_high(address_high),
    .address_low(address_low)
  );

  // line predictor state
  logic [7:0] line_copy [LINE_BYTES];
  int         line_wr_pos;
  logic [1:0] link_copy;
  logic [7:0] addr_copy [ADDR_LEN];

  logic [7:0] rx_backlog [$];
  res_t       expected_reports [$];
  int         rx_total;
  int         rx_accepted;
  bit         backlog_ready;
  int         mismatches;

  int burst_left;
  int gap_left;
  int pop_mode;
  int pop_mode_left;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] mark_char(input logic [MARK_W-1:0] mark, input int mlen,
                                           input int k);
    return mark[8*(mlen-1-k) +: 8];
  endfunction

  // first position of a marker inside the text, -1 when absent
  function automatic int find_marker(input logic [MARK_W-1:0] mark, input int mlen,
                                     input int tlen);
    int s;
    int k;
    bit hit;
    for (s = 0; s + mlen <= tlen; s++) begin
      hit = 1'b1;
      for (k = 0; k < mlen; k++) begin
        if (line_copy[s+k] != mark_char(mark, mlen, k)) hit = 1'b0;
      end
      if (hit) return s;
    end
    return -1;
  endfunction

  task automatic clear_line();
    int i;
    for (i = 0; i < LINE_BYTES; i++) line_copy[i] = 8'h00;
    line_wr_pos = 0;
  endtask

  task automatic classify_rx_byte(input logic [7:0] b);
    res_t r;
    int tlen;
    int pos;
    int i;
    int p;
    line_copy[line_wr_pos] = b;
    line_wr_pos = (line_wr_pos + 1) % LINE_BYTES;
    r.line_event = EV_NONE;
    if (b == NEWLINE_CHAR) begin
      tlen = LINE_BYTES;
      for (i = LINE_BYTES - 1; i >= 0; i--) begin
        if (line_copy[i] == 8'h00) tlen = i;
      end
      if (find_marker(M_BYPASS, LEN_BYPASS, tlen) >= 0) begin
        link_copy = LINK_CONNECTED;
        r.line_event = EV_CONNECTED;
      end else if (find_marker(M_DOWN, LEN_DOWN, tlen) >= 0) begin
        link_copy = LINK_DISCONNECTED;
        r.line_event = EV_DOWN;
      end else begin
        pos = find_marker(M_ADDR, LEN_ADDR, tlen);
        if (pos >= 0) begin
          link_copy = LINK_DISCONNECTED;
          r.line_event = EV_ADDRESS;
          for (i = 0; i < ADDR_LEN; i++) begin
            p = pos + ADDR_OFFSET + i;
            addr_copy[i] = (p < LINE_BYTES) ? line_copy[p] : 8'h00;
          end
        end
      end
      clear_line();
    end
    r.link_state = link_copy;
    r.address_high = '0;
    r.address_low = '0;
    for (i = 0; i < 6; i++) begin
      r.address_high = {r.address_high[39:0], addr_copy[i]};
      r.address_low = {r.address_low[39:0], addr_copy[i+6]};
    end
    expected_reports.push_back(r);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) rx_backlog.push_back(s[i]);
  endtask

  task automatic add_fill(input int n, input int lo, input int hi);
    int i;
    for (i = 0; i < n; i++) rx_backlog.push_back(8'($urandom_range(lo, hi)));
  endtask

  // flip_at >= 0 spoils one character so the marker no longer matches
  task automatic add_marker(input logic [MARK_W-1:0] mark, input int mlen, input int flip_at);
    int k;
    logic [7:0] c;
    for (k = 0; k < mlen; k++) begin
      c = mark_char(mark, mlen, k);
      if (k == flip_at) c = c ^ 8'h20;
      rx_backlog.push_back(c);
    end
  endtask

  task automatic add_hex(input int n);
    string digits;
    int i;
    digits = "0123456789ABCDEF";
    for (i = 0; i < n; i++) rx_backlog.push_back(digits[$urandom_range(0, 15)]);
  endtask

  task automatic end_line();
    rx_backlog.push_back(NEWLINE_CHAR);
  endtask

  task automatic note_mismatch(input string what, input logic [47:0] want,
                               input logic [47:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
  endtask

  // stimulus
  initial begin
    int kind;
    int which;
    int flip;
    clear_line();
    link_copy = LINK_UNKNOWN;
    for (int i = 0; i < ADDR_LEN; i++) addr_copy[i] = 8'h00;
    rx_accepted = 0;
    mismatches = 0;
    backlog_ready = 1'b0;

    // empty line, then each marker on its own
    end_line();
    add_marker(M_BYPASS, LEN_BYPASS, -1);
    end_line();
    add_marker(M_DOWN, LEN_DOWN, -1);
    end_line();
    add_marker(M_ADDR, LEN_ADDR, -1);
    add_text(" 00802512A3F7");
    end_line();
    // near miss: first character missing
    add_marker(M_BYPASS, LEN_BYPASS - 1, -1);
    end_line();
    // priority among several markers
    add_marker(M_DOWN, LEN_DOWN, -1);
    add_text(" ");
    add_marker(M_BYPASS, LEN_BYPASS, -1);
    end_line();
    add_marker(M_ADDR, LEN_ADDR, -1);
    add_text(" 111111111111 ");
    add_marker(M_DOWN, LEN_DOWN, -1);
    end_line();
    // two address markers, the first one wins
    add_marker(M_ADDR, LEN_ADDR, -1);
    add_text(" AAAAAAAAAAAA ");
    add_marker(M_ADDR, LEN_ADDR, -1);
    add_text(" BBBBBBBBBBBB");
    end_line();
    // zero byte ahead of a marker hides it
    add_text("ab");
    rx_backlog.push_back(8'h00);
    add_marker(M_BYPASS, LEN_BYPASS, -1);
    end_line();
    rx_backlog.push_back(8'h00);
    add_marker(M_DOWN, LEN_DOWN, -1);
    end_line();
    // zero byte inside the captured address is taken raw
    add_marker(M_ADDR, LEN_ADDR, -1);
    add_text(" 12");
    rx_backlog.push_back(8'h00);
    add_text("3456789AB");
    end_line();
    // capture running past the store end, store full of nonzero bytes
    add_fill(40, "x", "x");
    add_marker(M_ADDR, LEN_ADDR, -1);
    add_text(" ABCDEFG");
    end_line();
    // wrapped lines, one hiding a marker and one holding it
    add_fill(60, "z", "z");
    add_marker(M_BYPASS, LEN_BYPASS, -1);
    end_line();
    add_fill(64, "q", "q");
    add_marker(M_BYPASS, LEN_BYPASS, -1);
    end_line();
    // extreme byte values
    rx_backlog.push_back(8'hFF);
    rx_backlog.push_back(8'h80);
    rx_backlog.push_back(8'h7F);
    rx_backlog.push_back(8'h01);
    end_line();

    // random lines, mostly well formed
    while (rx_backlog.size() < 780) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        add_fill(($urandom_range(0, 3) == 0) ? $urandom_range(0, 45) : $urandom_range(0, 6),
                 32, 126);
        which = $urandom_range(0, 3);
        flip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, LEN_ADDR - 1) : -1;
        case (which)
          0: add_marker(M_BYPASS, LEN_BYPASS, flip);
          1: add_marker(M_DOWN, LEN_DOWN, flip);
          2: begin
            add_marker(M_ADDR, LEN_ADDR, flip);
            add_fill(1, 32, 126);
            add_hex(($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : ADDR_LEN);
          end
          default: add_fill($urandom_range(0, 10), 32, 126);
        endcase
        if ($urandom_range(0, 4) == 0) begin
          add_fill(1, 32, 126);
          case ($urandom_range(0, 2))
            0: add_marker(M_BYPASS, LEN_BYPASS, -1);
            1: add_marker(M_DOWN, LEN_DOWN, -1);
            default: add_marker(M_ADDR, LEN_ADDR, -1);
          endcase
        end
        add_fill($urandom_range(0, 4), 32, 126);
        if ($urandom_range(0, 15) == 0) rx_backlog.push_back(8'h00);
        end_line();
      end else if (kind < 9) begin
        add_fill($urandom_range(1, 90), 0, 255);
        if ($urandom_range(0, 1) == 0) end_line();
      end else begin
        add_fill($urandom_range(50, 100), 32, 126);
        case ($urandom_range(0, 2))
          0: add_marker(M_BYPASS, LEN_BYPASS, -1);
          1: add_marker(M_DOWN, LEN_DOWN, -1);
          default: begin
            add_marker(M_ADDR, LEN_ADDR, -1);
            add_fill(1, 32, 126);
            add_hex(ADDR_LEN);
          end
        endcase
        end_line();
      end
    end
    end_line();
    rx_total = rx_backlog.size();
    backlog_ready = 1'b1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!(rx_accepted == rx_total && expected_reports.size() == 0)) @(posedge clk);
    repeat (LINE_BYTES + 16) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("[modem_response_line_classifier_unit] OK");
    end else begin
      $display("[modem_response_line_classifier_unit] ERROR");
    end
    $finish;
  end

  // byte driver, bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        classify_rx_byte(rx_byte);
        rx_accepted++;
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (backlog_ready && rx_backlog.size() > 0) begin
          rx_byte <= rx_backlog.pop_front();
          push <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pop <= 1'b0;
      pop_mode = 0;
      pop_mode_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          note_mismatch("unexpected transaction", 48'h0, {44'h0, link_state, line_event});
        end else begin
          want = expected_reports.pop_front();
          if (link_state !== want.link_state)
            note_mismatch("link_state", 48'(want.link_state), 48'(link_state));
          if (line_event !== want.line_event)
            note_mismatch("line_event", 48'(want.line_event), 48'(line_event));
          if (address_high !== want.address_high)
            note_mismatch("address_high", want.address_high, address_high);
          if (address_low !== want.address_low)
            note_mismatch("address_low", want.address_low, address_low);
        end
      end
      if (pop_mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_mode_left = $urandom_range(20, 200);
      end else begin
        pop_mode_left--;
      end
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= ((pop_mode_left % 32) < 4);
      endcase
    end
  end

  initial begin
    #10_000_000;
    $display("[modem_response_line_classifier_unit] ERROR");
    $finish;
  end

endmodule

// ===== modem_response_line_classifier_unit.f =====
+incdir+src
src/mrlc_pkg.sv
src/mrlc_fifo.sv
src/mrlc_front.sv
src/mrlc_back.sv
src/modem_response_line_classifier_unit.sv
verif/modem_response_line_classifier_unit_tb.sv
